[sv/tiff_pkg.sv]
// ----------------------------------------------------------------------------
// tiff_pkg: shared types and helpers for the TIFF directory entry parser
// Holds the channel item structs, result status codes and byte-order helpers.
// ----------------------------------------------------------------------------
package tiff_pkg;

    // Result status codes
    localparam logic [2:0] STAT_ENTRY       = 3'd0;
    localparam logic [2:0] STAT_UNKNOWN     = 3'd1;
    localparam logic [2:0] STAT_BYTE_ORDER  = 3'd2;
    localparam logic [2:0] STAT_MAGIC       = 3'd3;
    localparam logic [2:0] STAT_TAG_ORDER   = 3'd4;
    localparam logic [2:0] STAT_OFF_BEHIND  = 3'd5;
    localparam logic [2:0] STAT_EMPTY_DIR   = 3'd6;

    // Header constants
    localparam logic [7:0]  MARK_LITTLE  = 8'h49;
    localparam logic [7:0]  MARK_BIG     = 8'h4d;
    localparam logic [15:0] TIFF_MAGIC   = 16'd42;
    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [3:0]  ENTRY_LAST   = 4'd11;  // index of final byte of a 12-byte entry

    // Input item: one file byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } tiff_in_t;

    // Result item
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_index;
        logic [15:0] tag_id;
        logic [15:0] data_type;
        logic [31:0] value_count;
        logic        offset_flag;
        logic [31:0] value_field;
        logic        last_entry;
    } tiff_out_t;

    // Raw bytes of one directory entry, element 0 first in file order
    typedef logic [11:0][7:0] tiff_bytes_t;

    // Decoded entry fields
    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] dtype;
        logic [31:0] count;
        logic        offset_flag;
        logic [31:0] field;
        logic        unknown;
    } tiff_entry_t;

    function automatic logic [15:0] ord16(input logic be, input logic [7:0] a,
                                          input logic [7:0] b);
        return be ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] ord32(input logic be, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [7:0] b3);
        return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

endpackage

[sv/tiff_entry_dec.sv]
// ----------------------------------------------------------------------------
// tiff_entry_dec: decode of one 12-byte directory entry
// Byte-orders tag, type, count and value, and picks inline value or offset.
// ----------------------------------------------------------------------------
module tiff_entry_dec
    import tiff_pkg::*;
(
    input  tiff_bytes_t entry_bytes,
    input  logic        big_endian,
    output tiff_entry_t entry
);

    // Field type codes
    localparam logic [15:0] TYPE_BYTE      = 16'd1;
    localparam logic [15:0] TYPE_ASCII     = 16'd2;
    localparam logic [15:0] TYPE_SHORT     = 16'd3;
    localparam logic [15:0] TYPE_LONG      = 16'd4;
    localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
    localparam logic [15:0] TYPE_SBYTE     = 16'd6;
    localparam logic [15:0] TYPE_UNDEF     = 16'd7;
    localparam logic [15:0] TYPE_SSHORT    = 16'd8;
    localparam logic [15:0] TYPE_SLONG     = 16'd9;
    localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
    localparam logic [15:0] TYPE_FLOAT     = 16'd11;
    localparam logic [15:0] TYPE_DOUBLE    = 16'd12;
    localparam logic [15:0] TYPE_IFD       = 16'd13;
    localparam logic [15:0] TYPE_LONG8     = 16'd16;
    localparam logic [15:0] TYPE_SLONG8    = 16'd17;
    localparam logic [15:0] TYPE_IFD8      = 16'd18;

    logic [31:0] val;

    always_comb
    begin
        entry.tag   = ord16(big_endian, entry_bytes[0], entry_bytes[1]);
        entry.dtype = ord16(big_endian, entry_bytes[2], entry_bytes[3]);
        entry.count = ord32(big_endian, entry_bytes[4], entry_bytes[5],
                            entry_bytes[6], entry_bytes[7]);
        val         = ord32(big_endian, entry_bytes[8], entry_bytes[9],
                            entry_bytes[10], entry_bytes[11]);
        entry.field       = val;
        entry.offset_flag = 1'b0;
        entry.unknown     = 1'b0;

        // inline value when it fits in four bytes
        case (entry.dtype)
            TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEF:
            begin
                if (entry.count > 32'd4)
                    entry.offset_flag = 1'b1;
                else
                    entry.field = {entry_bytes[11], entry_bytes[10],
                                   entry_bytes[9], entry_bytes[8]};
            end
            TYPE_SHORT, TYPE_SSHORT:
            begin
                if (entry.count > 32'd2)
                    entry.offset_flag = 1'b1;
                else
                    entry.field = {ord16(big_endian, entry_bytes[10], entry_bytes[11]),
                                   ord16(big_endian, entry_bytes[8], entry_bytes[9])};
            end
            TYPE_LONG, TYPE_SLONG:
            begin
                entry.offset_flag = (entry.count > 32'd1);
            end
            TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_FLOAT, TYPE_DOUBLE,
            TYPE_IFD, TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8:
            begin
                entry.offset_flag = 1'b1;
            end
            default:
            begin
                entry.unknown = 1'b1;
            end
        endcase
    end

endmodule

[sv/tiff_parser.sv]
// ----------------------------------------------------------------------------
// tiff_parser: byte-serial header and first-directory parser
// Tracks the file position and parse phase, one accepted byte per cycle.
// ----------------------------------------------------------------------------
module tiff_parser
    import tiff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  tiff_in_t  item,
    output logic      res_push,
    output tiff_out_t res
);

    // Parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_ENTRY  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_HALT   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic        be_reg, be_next;
    logic [31:0] dir_off_reg, dir_off_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] counter_reg, counter_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] prev_tag_reg, prev_tag_next;
    tiff_bytes_t eb_reg, eb_next;

    // state as seen by this byte (start_of_file clears first)
    logic [2:0]  cur_phase;
    logic [31:0] cur_pos;
    logic        cur_be;
    logic [31:0] cur_off;
    logic [15:0] cur_left;
    logic [15:0] cur_counter;
    logic [3:0]  cur_idx;
    logic [15:0] cur_prev;
    logic [2:0]  eff_phase;
    logic [3:0]  eff_idx;
    logic [7:0]  b;
    logic [31:0] off_acc;
    logic [15:0] cnt;

    tiff_bytes_t dec_bytes;
    tiff_entry_t entry;

    always_comb
    begin
        dec_bytes     = eb_reg;
        dec_bytes[11] = item.data_byte;
    end

    tiff_entry_dec u_dec (
        .entry_bytes (dec_bytes),
        .big_endian  (cur_be),
        .entry       (entry)
    );

    // next-state and result logic
    always_comb
    begin
        b           = item.data_byte;
        cur_phase   = item.start_of_file ? PH_HEADER : phase_reg;
        cur_pos     = item.start_of_file ? 32'd0 : pos_reg;
        cur_be      = item.start_of_file ? 1'b0 : be_reg;
        cur_off     = item.start_of_file ? 32'd0 : dir_off_reg;
        cur_left    = item.start_of_file ? 16'd0 : left_reg;
        cur_counter = item.start_of_file ? 16'd0 : counter_reg;
        cur_idx     = item.start_of_file ? 4'd0 : idx_reg;
        cur_prev    = item.start_of_file ? 16'd0 : prev_tag_reg;

        phase_next    = cur_phase;
        pos_next      = cur_pos + 32'd1;
        be_next       = cur_be;
        dir_off_next  = cur_off;
        left_next     = cur_left;
        counter_next  = cur_counter;
        idx_next      = cur_idx;
        prev_tag_next = cur_prev;
        eb_next       = eb_reg;
        res_push      = 1'b0;
        res           = '0;
        off_acc       = '0;
        cnt           = '0;

        // directory start reached while skipping: treat this byte as count
        eff_phase = cur_phase;
        eff_idx   = cur_idx;
        if (cur_phase == PH_SKIP && cur_pos == cur_off)
        begin
            eff_phase = PH_COUNT;
            eff_idx   = 4'd0;
        end

        case (eff_phase)
            PH_HEADER:
            begin
                if (cur_pos == 32'd0)
                    eb_next[0] = b;
                else if (cur_pos == 32'd1)
                begin
                    if (eb_reg[0] != b || (b != MARK_LITTLE && b != MARK_BIG))
                    begin
                        res_push   = 1'b1;
                        res.status = STAT_BYTE_ORDER;
                        phase_next = PH_HALT;
                    end
                    else
                        be_next = (b == MARK_BIG);
                end
                else if (cur_pos == 32'd2)
                    eb_next[2] = b;
                else if (cur_pos == 32'd3)
                begin
                    if (ord16(cur_be, eb_reg[2], b) != TIFF_MAGIC)
                    begin
                        res_push   = 1'b1;
                        res.status = STAT_MAGIC;
                        phase_next = PH_HALT;
                    end
                end
                else if (cur_pos <= 32'd7)
                begin
                    // offset bytes 4..7 assembled per byte order
                    if (cur_be)
                        off_acc = {cur_off[23:0], b};
                    else
                        off_acc = cur_off | ({24'd0, b} << {cur_pos[1:0], 3'b000});
                    dir_off_next = off_acc;
                    if (cur_pos == 32'd7)
                    begin
                        idx_next = 4'd0;
                        if (off_acc < HEADER_BYTES)
                        begin
                            res_push   = 1'b1;
                            res.status = STAT_OFF_BEHIND;
                            phase_next = PH_HALT;
                        end
                        else
                            phase_next = (off_acc == HEADER_BYTES) ? PH_COUNT : PH_SKIP;
                    end
                end
                else
                    phase_next = PH_HALT;
            end
            PH_COUNT:
            begin
                if (eff_idx == 4'd0)
                begin
                    eb_next[0] = b;
                    idx_next   = 4'd1;
                    phase_next = PH_COUNT;
                end
                else
                begin
                    cnt      = ord16(cur_be, eb_reg[0], b);
                    idx_next = 4'd0;
                    if (cnt == 16'd0)
                    begin
                        res_push   = 1'b1;
                        res.status = STAT_EMPTY_DIR;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        left_next    = cnt;
                        counter_next = 16'd0;
                        phase_next   = PH_ENTRY;
                    end
                end
            end
            PH_ENTRY:
            begin
                if (eff_idx != ENTRY_LAST)
                begin
                    eb_next[eff_idx] = b;
                    idx_next         = eff_idx + 4'd1;
                end
                else
                begin
                    eb_next[ENTRY_LAST] = b;
                    idx_next            = 4'd0;
                    res_push            = 1'b1;
                    if (cur_counter != 16'd0 && cur_prev >= entry.tag)
                    begin
                        res.status      = STAT_TAG_ORDER;
                        res.entry_index = cur_counter;
                        res.tag_id      = entry.tag;
                        phase_next      = PH_HALT;
                    end
                    else
                    begin
                        prev_tag_next   = entry.tag;
                        res.status      = entry.unknown ? STAT_UNKNOWN : STAT_ENTRY;
                        res.entry_index = cur_counter;
                        res.tag_id      = entry.tag;
                        res.data_type   = entry.dtype;
                        res.value_count = entry.count;
                        res.offset_flag = entry.offset_flag;
                        res.value_field = entry.field;
                        res.last_entry  = (cur_left == 16'd1);
                        left_next       = cur_left - 16'd1;
                        counter_next    = cur_counter + 16'd1;
                        if (cur_left == 16'd1)
                            phase_next = PH_DONE;
                    end
                end
            end
            default:
            begin
                // skipping, done or halted: byte consumed without result
            end
        endcase

        res_push = res_push & accept;
    end

    // entry byte store, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            eb_reg <= eb_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            be_reg       <= 1'b0;
            dir_off_reg  <= '0;
            left_reg     <= '0;
            counter_reg  <= '0;
            idx_reg      <= '0;
            prev_tag_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            be_reg       <= be_next;
            dir_off_reg  <= dir_off_next;
            left_reg     <= left_next;
            counter_reg  <= counter_next;
            idx_reg      <= idx_next;
            prev_tag_reg <= prev_tag_next;
        end
    end

    // checks
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> accept)
        else $error("result pushed without an accepted item");

    a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.start_of_file &&
         (phase_reg == PH_DONE || phase_reg == PH_HALT)) |-> !res_push)
        else $error("result produced after directory end or halt");

    a_entry_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ENTRY) |-> (left_reg != 16'd0))
        else $error("entry phase with no entries left");

    a_tag_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.status == STAT_TAG_ORDER) |=> (phase_reg == PH_HALT))
        else $error("tag order error did not halt parser");

endmodule

[sv/tiff_out_buf.sv]
// ----------------------------------------------------------------------------
// tiff_out_buf: result output register
// Holds one result item until taken; frees its slot in the cycle it drains.
// ----------------------------------------------------------------------------
module tiff_out_buf
    import tiff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tiff_out_t push_data,
    output logic      space,
    output logic      valid,
    input  logic      ready,
    output tiff_out_t data
);

    logic      valid_reg, valid_next;
    tiff_out_t data_reg;

    // slot free when empty or being taken this cycle
    assign space      = !valid_reg || ready;
    assign valid_next = push || (valid_reg && !ready);
    assign valid      = valid_reg;
    assign data       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg <= push_data;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result pushed into a full output register");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (valid_reg && data_reg == $past(push_data)))
        else $error("pushed result not presented");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ready && !push) |=> !valid_reg)
        else $error("taken result still shown");

endmodule

[sv/tiff_header_ifd_entry_parser.sv]
// ----------------------------------------------------------------------------
// tiff_header_ifd_entry_parser: TIFF header check and first directory decode
//
// Input channel (data_valid/data_ready/data_item) carries the file one byte
// per item from offset 0; start_of_file marks offset 0 and restarts parsing.
// Output channel (entry_valid/entry_ready/entry_item) carries one result per
// directory entry, plus one result for a header error, a backward directory
// offset, an empty directory or a tag order error. After an error the block
// drops bytes without result until the next start_of_file.
//
// Throughput: one byte per cycle while entry_ready takes each result. Each
// byte is parsed by combinational logic into the output register, so a result
// is shown in the cycle after the byte that completes it is accepted.
// Stall: data_ready is low only while the output register holds a result
// that entry_ready does not take in that cycle.
// Reset: rst_n clears the parser to the header phase and empties the output
// register; the first byte after reset is parsed as offset 0.
// ----------------------------------------------------------------------------
module tiff_header_ifd_entry_parser
    import tiff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      data_valid,
    output logic      data_ready,
    input  tiff_in_t  data_item,
    output logic      entry_valid,
    input  logic      entry_ready,
    output tiff_out_t entry_item
);

    logic      accept;
    logic      space;
    logic      res_push;
    tiff_out_t res;

    assign data_ready = space;
    assign accept     = data_valid && space;

    // byte parser
    tiff_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (data_item),
        .res_push (res_push),
        .res      (res)
    );

    // result register
    tiff_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .space     (space),
        .valid     (entry_valid),
        .ready     (entry_ready),
        .data      (entry_item)
    );

endmodule

[test/tiff_tb_pkg.sv]
// ----------------------------------------------------------------------------
// tiff_tb_pkg: field type codes used by the directory parser testbench
// Shared by the stimulus generator and the entry checker.
// ----------------------------------------------------------------------------
package tiff_tb_pkg;

    // Defined TIFF field types
    localparam logic [15:0] TYPE_BYTE       = 16'd1;
    localparam logic [15:0] TYPE_ASCII      = 16'd2;
    localparam logic [15:0] TYPE_SHORT      = 16'd3;
    localparam logic [15:0] TYPE_LONG       = 16'd4;
    localparam logic [15:0] TYPE_RATIONAL   = 16'd5;
    localparam logic [15:0] TYPE_SBYTE      = 16'd6;
    localparam logic [15:0] TYPE_UNDEFINED  = 16'd7;
    localparam logic [15:0] TYPE_SSHORT     = 16'd8;
    localparam logic [15:0] TYPE_SLONG      = 16'd9;
    localparam logic [15:0] TYPE_SRATIONAL  = 16'd10;
    localparam logic [15:0] TYPE_FLOAT      = 16'd11;
    localparam logic [15:0] TYPE_DOUBLE     = 16'd12;
    localparam logic [15:0] TYPE_IFD        = 16'd13;
    localparam logic [15:0] TYPE_LONG8      = 16'd16;
    localparam logic [15:0] TYPE_SLONG8     = 16'd17;
    localparam logic [15:0] TYPE_IFD8       = 16'd18;

    // Codes the parser does not know
    localparam logic [15:0] TYPE_VOID       = 16'd0;
    localparam logic [15:0] TYPE_RESERVED_A = 16'd14;
    localparam logic [15:0] TYPE_RESERVED_B = 16'd15;
    localparam int          TYPE_FIRST_FREE = 19;

    // Size of one directory entry in bytes
    localparam int ENTRY_BYTES = 12;

endpackage

[test/tiff_entry_checker.sv]
// ----------------------------------------------------------------------------
// tiff_entry_checker: predicts and checks the directory parser results
// Watches both channels, decodes each accepted byte with its own parser
// model and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tiff_entry_checker
    import tiff_pkg::*, tiff_tb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      data_valid,
    input  logic      data_ready,
    input  tiff_in_t  data_item,
    input  logic      entry_valid,
    input  logic      entry_ready,
    input  tiff_out_t entry_item,
    output int        fail_count,
    output int        backlog,
    output int        results_seen,
    output int        error_reports
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEEK,
        PH_COUNT,
        PH_ENTRY,
        PH_DONE,
        PH_HALT
    } phase_t;

    // Parser model state
    phase_t      phase;
    logic [31:0] pos;
    logic [31:0] dir_off;
    logic        big_end;
    logic [15:0] left;
    logic [15:0] idx;
    logic [15:0] prev_tag;
    logic [3:0]  bidx;
    logic [7:0]  raw [ENTRY_BYTES];

    tiff_out_t   expected_q[$];
    int          mism = 0;
    int          nres = 0;
    int          nerr = 0;

    function automatic logic [15:0] join16(input logic [7:0] a, input logic [7:0] b);
        return big_end ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] join32(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
        return big_end ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    task automatic clear_parser();
        phase    = PH_HEADER;
        pos      = '0;
        dir_off  = '0;
        big_end  = 1'b0;
        left     = '0;
        idx      = '0;
        prev_tag = '0;
        bidx     = '0;
        for (int i = 0; i < ENTRY_BYTES; i++)
            raw[i] = '0;
    endtask

    // One accepted byte through the model; queue the result it causes
    task automatic predict_byte(input logic [7:0] b, input logic sof);
        logic [31:0] p;
        logic [31:0] cnt;
        logic [31:0] fld;
        logic [15:0] tag;
        logic [15:0] dtype;
        logic [15:0] n16;
        logic        off;
        logic [2:0]  st;
        logic        emit;
        tiff_out_t   r;
        if (sof)
            clear_parser();
        r    = '0;
        emit = 1'b0;
        p    = pos;
        pos  = pos + 32'd1;

        if (phase == PH_HEADER)
        begin
            if (p == 0)
                raw[0] = b;
            else if (p == 1)
            begin
                if (raw[0] != b || (b != MARK_LITTLE && b != MARK_BIG))
                begin
                    r.status = STAT_BYTE_ORDER;
                    emit     = 1'b1;
                    phase    = PH_HALT;
                end
                else
                    big_end = (b == MARK_BIG);
            end
            else if (p == 2)
                raw[2] = b;
            else if (p == 3)
            begin
                if (join16(raw[2], b) != TIFF_MAGIC)
                begin
                    r.status = STAT_MAGIC;
                    emit     = 1'b1;
                    phase    = PH_HALT;
                end
            end
            else if (p <= 7)
            begin
                if (big_end)
                    dir_off = {dir_off[23:0], b};
                else
                    dir_off = dir_off | ({24'd0, b} << (8 * (p - 4)));
                if (p == 7)
                begin
                    if (dir_off < HEADER_BYTES)
                    begin
                        r.status = STAT_OFF_BEHIND;
                        emit     = 1'b1;
                        phase    = PH_HALT;
                    end
                    else
                    begin
                        phase = (dir_off == HEADER_BYTES) ? PH_COUNT : PH_SEEK;
                        bidx  = '0;
                    end
                end
            end
            else
                phase = PH_HALT;
        end
        else
        begin
            // arriving at the directory falls through into the count
            if (phase == PH_SEEK && p == dir_off)
            begin
                phase = PH_COUNT;
                bidx  = '0;
            end

            if (phase == PH_COUNT)
            begin
                if (bidx == 0)
                begin
                    raw[0] = b;
                    bidx   = 4'd1;
                end
                else
                begin
                    n16  = join16(raw[0], b);
                    bidx = '0;
                    if (n16 == 0)
                    begin
                        r.status = STAT_EMPTY_DIR;
                        emit     = 1'b1;
                        phase    = PH_DONE;
                    end
                    else
                    begin
                        left  = n16;
                        idx   = '0;
                        phase = PH_ENTRY;
                    end
                end
            end
            else if (phase == PH_ENTRY)
            begin
                if (bidx >= ENTRY_BYTES)
                    bidx = '0;
                raw[bidx] = b;
                bidx      = bidx + 4'd1;
                if (bidx == ENTRY_BYTES)
                begin
                    bidx  = '0;
                    tag   = join16(raw[0], raw[1]);
                    dtype = join16(raw[2], raw[3]);
                    cnt   = join32(raw[4], raw[5], raw[6], raw[7]);
                    fld   = join32(raw[8], raw[9], raw[10], raw[11]);

                    if (idx > 0 && prev_tag >= tag)
                    begin
                        r.status      = STAT_TAG_ORDER;
                        r.entry_index = idx;
                        r.tag_id      = tag;
                        emit          = 1'b1;
                        phase         = PH_HALT;
                    end
                    else
                    begin
                        prev_tag = tag;
                        off      = 1'b0;
                        st       = STAT_ENTRY;
                        // inline or offset, by type class and count
                        case (dtype)
                            TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEFINED:
                                if (cnt > 4)
                                    off = 1'b1;
                                else
                                    fld = {raw[11], raw[10], raw[9], raw[8]};
                            TYPE_SHORT, TYPE_SSHORT:
                                if (cnt > 2)
                                    off = 1'b1;
                                else
                                    fld = {join16(raw[10], raw[11]), join16(raw[8], raw[9])};
                            TYPE_LONG, TYPE_SLONG:
                                off = (cnt > 1);
                            TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_FLOAT, TYPE_DOUBLE,
                            TYPE_IFD, TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8:
                                off = 1'b1;
                            default:
                                st = STAT_UNKNOWN;
                        endcase
                        r.status      = st;
                        r.entry_index = idx;
                        r.tag_id      = tag;
                        r.data_type   = dtype;
                        r.value_count = cnt;
                        r.offset_flag = off;
                        r.value_field = fld;
                        r.last_entry  = (left == 16'd1);
                        emit          = 1'b1;
                        left          = left - 16'd1;
                        idx           = idx + 16'd1;
                        if (r.last_entry)
                            phase = PH_DONE;
                    end
                end
            end
        end

        if (emit)
            expected_q.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mism++;
            if (mism <= 40)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    task automatic check_result(input tiff_out_t act);
        tiff_out_t want;
        nres++;
        if (act.status !== STAT_ENTRY && act.status !== STAT_UNKNOWN)
            nerr++;
        if (expected_q.size() == 0)
        begin
            mism++;
            if (mism <= 40)
                $display("%0t: unexpected result item: expected none, actual status %0d",
                         $time, act.status);
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("status",      32'(want.status),      32'(act.status));
            check_field("entry_index", 32'(want.entry_index), 32'(act.entry_index));
            check_field("tag_id",      32'(want.tag_id),      32'(act.tag_id));
            check_field("data_type",   32'(want.data_type),   32'(act.data_type));
            check_field("value_count", want.value_count,      act.value_count);
            check_field("offset_flag", 32'(want.offset_flag), 32'(act.offset_flag));
            check_field("value_field", want.value_field,      act.value_field);
            check_field("last_entry",  32'(want.last_entry),  32'(act.last_entry));
        end
    endtask

    // Results show in the cycle after their byte, so compare before predicting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_q.delete();
        end
        else
        begin
            if (entry_valid && entry_ready)
                check_result(entry_item);
            if (data_valid && data_ready)
                predict_byte(data_item.data_byte, data_item.start_of_file);
        end
        backlog       <= expected_q.size();
        fail_count    <= mism;
        results_seen  <= nres;
        error_reports <= nerr;
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top for the TIFF header and first directory parser
// Builds TIFF byte streams (well-formed files, broken headers, unsorted or
// truncated directories, noise), feeds them with random gaps and output
// stalls, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb
    import tiff_pkg::*, tiff_tb_pkg::*;
();

    localparam int TARGET_BYTES = 1700;
    localparam int QUIET_BYTES  = 1450;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [15:0] KNOWN_TYPES [16] = '{
        TYPE_BYTE, TYPE_ASCII, TYPE_SHORT, TYPE_LONG, TYPE_RATIONAL, TYPE_SBYTE,
        TYPE_UNDEFINED, TYPE_SSHORT, TYPE_SLONG, TYPE_SRATIONAL, TYPE_FLOAT,
        TYPE_DOUBLE, TYPE_IFD, TYPE_LONG8, TYPE_SLONG8, TYPE_IFD8
    };

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      data_valid  = 1'b0;
    logic      data_ready;
    tiff_in_t  data_item   = '0;
    logic      entry_valid;
    logic      entry_ready = 1'b0;
    tiff_out_t entry_item;

    int fail_count;
    int backlog;
    int results_seen;
    int error_reports;

    logic [7:0] file_q[$];
    logic       gen_be;
    int         useful_bytes = 0;
    int         bytes_sent   = 0;
    int         files_sent   = 0;
    int         idle_rate    = 0;
    int         stall_rate   = 0;
    int         stall_left   = 0;
    int         quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tiff_header_ifd_entry_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_ready  (data_ready),
        .data_item   (data_item),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .entry_item  (entry_item)
    );

    tiff_entry_checker CHK (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_ready    (data_ready),
        .data_item     (data_item),
        .entry_valid   (entry_valid),
        .entry_ready   (entry_ready),
        .entry_item    (entry_item),
        .fail_count    (fail_count),
        .backlog       (backlog),
        .results_seen  (results_seen),
        .error_reports (error_reports)
    );

    // Result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            entry_ready <= 1'b0;
        end
        else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            entry_ready <= 1'b0;
        end
        else
            entry_ready <= 1'b1;
    end

    // Watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((data_valid && data_ready) || (entry_valid && entry_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog: no handshake for %0d cycles, %0d results pending",
                         $time, quiet_cycles, backlog);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // File image builders
    task automatic put8(input logic [7:0] b);
        file_q.push_back(b);
        useful_bytes++;
    endtask

    task automatic put16(input logic [15:0] v);
        if (gen_be)
        begin
            put8(v[15:8]);
            put8(v[7:0]);
        end
        else
        begin
            put8(v[7:0]);
            put8(v[15:8]);
        end
    endtask

    task automatic put32(input logic [31:0] v);
        if (gen_be)
        begin
            put16(v[31:16]);
            put16(v[15:0]);
        end
        else
        begin
            put16(v[15:0]);
            put16(v[31:16]);
        end
    endtask

    task automatic put_header(input logic [31:0] off);
        put8(gen_be ? MARK_BIG : MARK_LITTLE);
        put8(gen_be ? MARK_BIG : MARK_LITTLE);
        put16(TIFF_MAGIC);
        put32(off);
    endtask

    task automatic put_entry(input logic [15:0] tag, input logic [15:0] dtype,
                             input logic [31:0] cnt, input logic [31:0] val);
        put16(tag);
        put16(dtype);
        put32(cnt);
        put32(val);
    endtask

    // filler the parser skips or ignores
    task automatic pad(input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] pick_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return KNOWN_TYPES[r];
        case (r)
            16: return TYPE_VOID;
            17: return ($urandom_range(0, 1) != 0) ? TYPE_RESERVED_A : TYPE_RESERVED_B;
            default: return 16'($urandom_range(TYPE_FIRST_FREE, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 32'($urandom_range(0, 5));
        else if (r == 7)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Byte driver: valid held until accepted
    task automatic send_byte(input logic [7:0] b, input logic sof);
        tiff_in_t it;
        it.data_byte     = b;
        it.start_of_file = sof;
        if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_item  <= it;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_file(input logic with_sof);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], with_sof && i == 0);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic drain();
        data_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // first file after reset without a start mark, inline shorts
        file_q.delete();
        gen_be = 1'b0;
        put_header(HEADER_BYTES);
        put16(16'd1);
        put_entry(16'h0000, TYPE_SHORT, 32'd2, 32'h1234_5678);
        send_file(1'b0);

        // big endian, gap before the directory, inline bytes, offset, tag max
        file_q.delete();
        gen_be = 1'b1;
        put_header(32'd11);
        pad(3);
        put16(16'd3);
        put_entry(16'h0100, TYPE_BYTE, 32'd4, 32'hA1B2_C3D4);
        put_entry(16'h0101, TYPE_ASCII, 32'd5, 32'h0000_0200);
        put_entry(16'hFFFF, TYPE_LONG, 32'd1, 32'hFFFF_FFFF);
        pad(2);
        send_file(1'b1);

        // mixed byte-order marks
        file_q.delete();
        put8(MARK_LITTLE);
        put8(MARK_BIG);
        pad(2);
        send_file(1'b1);

        // matching marks that are not byte-order marks
        file_q.delete();
        put8(8'h41);
        put8(8'h41);
        pad(2);
        send_file(1'b1);

        // wrong magic, little endian
        file_q.delete();
        gen_be = 1'b0;
        put8(MARK_LITTLE);
        put8(MARK_LITTLE);
        put16(TIFF_MAGIC + 16'd1);
        pad(4);
        send_file(1'b1);

        // magic written in the wrong byte order
        file_q.delete();
        gen_be = 1'b1;
        put8(MARK_BIG);
        put8(MARK_BIG);
        put8(TIFF_MAGIC[7:0]);
        put8(TIFF_MAGIC[15:8]);
        pad(4);
        send_file(1'b1);

        // directory offset inside the header
        file_q.delete();
        gen_be = 1'b0;
        put_header(32'd0);
        send_file(1'b1);
        file_q.delete();
        gen_be = 1'b1;
        put_header(HEADER_BYTES - 32'd1);
        pad(2);
        send_file(1'b1);

        // empty directory, trailing bytes ignored
        file_q.delete();
        gen_be = 1'b0;
        put_header(HEADER_BYTES);
        put16(16'd0);
        pad(3);
        send_file(1'b1);

        // unknown type, then a repeated tag halts the parse
        file_q.delete();
        gen_be = 1'b1;
        put_header(HEADER_BYTES);
        put16(16'd4);
        put_entry(16'd10, TYPE_RESERVED_A, 32'd3, 32'hDEAD_BEEF);
        put_entry(16'd20, TYPE_SRATIONAL, 32'd1, 32'h0000_0100);
        put_entry(16'd20, TYPE_SSHORT, 32'd3, 32'h0000_0200);
        pad(12);
        send_file(1'b1);

        // maximum count, signed shorts inline
        file_q.delete();
        gen_be = 1'b0;
        put_header(HEADER_BYTES);
        put16(16'd2);
        put_entry(16'd5, TYPE_LONG8, 32'hFFFF_FFFF, 32'h0000_0000);
        put_entry(16'd6, TYPE_SSHORT, 32'd2, 32'h8001_7FFE);
        send_file(1'b1);

        // cut off inside an entry; the next file restarts the parser
        file_q.delete();
        put_header(HEADER_BYTES);
        put16(16'd5);
        put_entry(16'd1, TYPE_FLOAT, 32'd1, 32'h3F80_0000);
        pad(5);
        send_file(1'b1);
    endtask

    task automatic build_random_file();
        int          kind;
        int          n;
        int          skip;
        int          bad_at;
        logic [15:0] tag;
        logic [15:0] magic;
        logic [7:0]  m0;
        logic [7:0]  m1;
        file_q.delete();
        gen_be = ($urandom_range(0, 1) != 0);
        kind   = $urandom_range(0, 99);

        if (kind < 9)
        begin
            // noise
            n = $urandom_range(3, 20);
            pad(n);
        end
        else if (kind < 14)
        begin
            // bad byte-order mark
            case ($urandom_range(0, 2))
                0: m0 = MARK_LITTLE;
                1: m0 = MARK_BIG;
                default: m0 = 8'($urandom);
            endcase
            m1 = ($urandom_range(0, 1) != 0) ? (m0 ^ 8'h04) : 8'($urandom);
            put8(m0);
            put8(m1);
            pad($urandom_range(2, 6));
        end
        else if (kind < 19)
        begin
            // bad magic
            put8(gen_be ? MARK_BIG : MARK_LITTLE);
            put8(gen_be ? MARK_BIG : MARK_LITTLE);
            magic = 16'($urandom);
            if (magic == TIFF_MAGIC)
                magic = {TIFF_MAGIC[7:0], TIFF_MAGIC[15:8]};
            put16(magic);
            pad($urandom_range(0, 8));
        end
        else if (kind < 23)
        begin
            // directory offset points into the header
            put_header(32'($urandom_range(0, 7)));
            pad($urandom_range(0, 4));
        end
        else if (kind < 27)
        begin
            // far directory offset, file abandoned on the way
            put_header($urandom | 32'h0000_1000);
            pad($urandom_range(1, 10));
        end
        else if (kind < 33)
        begin
            // entry count from 2 up, followed by no more than two entries
            put_header(HEADER_BYTES);
            put16(16'($urandom_range(2, 65535)));
            tag = 16'($urandom_range(0, 1000));
            n   = $urandom_range(0, 2);
            for (int j = 0; j < n; j++)
            begin
                put_entry(tag, pick_type(), pick_count(), $urandom);
                tag = tag + 16'($urandom_range(1, 9000));
            end
            pad($urandom_range(0, 11));
        end
        else if (kind < 38)
        begin
            // empty directory
            skip = $urandom_range(0, 3);
            put_header(HEADER_BYTES + 32'(skip));
            pad(skip);
            put16(16'd0);
            pad($urandom_range(0, 4));
        end
        else
        begin
            // complete directory, some with a tag out of order
            skip = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            put_header(HEADER_BYTES + 32'(skip));
            pad(skip);
            n = $urandom_range(1, 6);
            put16(16'(n));
            bad_at = (kind < 46 && n >= 2) ? $urandom_range(1, n - 1) : -1;
            tag    = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 12000));
            for (int j = 0; j < n; j++)
            begin
                if (j == bad_at)
                    tag = tag - 16'($urandom_range(0, (tag < 50) ? tag : 50));
                else if (j > 0)
                    tag = tag + 16'($urandom_range(1, 8000));
                if (j == n - 1 && j != bad_at && $urandom_range(0, 7) == 0)
                    tag = 16'hFFFF;
                put_entry(tag, pick_type(), pick_count(), $urandom);
            end
            pad($urandom_range(0, 3));
        end
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    // Stimulus and verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();

        useful_bytes = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            if (bytes_sent >= QUIET_BYTES)
            begin
                idle_rate  = 0;
                stall_rate = 0;
            end
            else
            begin
                idle_rate  = pick_rate();
                stall_rate = pick_rate();
            end
            build_random_file();
            send_file(1'b1);
            files_sent++;
            if (files_sent % 12 == 0)
                drain();
        end

        data_valid <= 1'b0;
        while (backlog != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d random files (%0d header and directory bytes), %0d bytes in all",
                 files_sent, useful_bytes, bytes_sent);
        $display("Checked %0d result items, %0d of them error reports", results_seen,
                 error_reports);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/tiff_pkg.sv
sv/tiff_entry_dec.sv
sv/tiff_parser.sv
sv/tiff_out_buf.sv
sv/tiff_header_ifd_entry_parser.sv
test/tiff_tb_pkg.sv
test/tiff_entry_checker.sv
test/tb.sv
